### hdl/dtpo_pkg.sv
// Shared types, constants and saturation helpers for the predictive observer.
`default_nettype none

package dtpo_pkg;

   localparam int DATA_W     = 32;
   localparam int COEF_W     = 32;
   localparam int COEF_FRAC  = 24;
   localparam int ACC_W      = 64;
   localparam int AXES_DEF   = 3;
   localparam int OUT_AXES   = 3;
   localparam int CSR_ADDR_W = 3;

   // Register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_A00  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_A01  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_A10  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_A11  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INJECT_C0 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INJECT_C1 = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_TIME = 3'd6;

   localparam logic signed [COEF_W-1:0] RST_GAIN_A00  = 32'sd7684758;
   localparam logic signed [COEF_W-1:0] RST_GAIN_A01  = 32'sd118227;
   localparam logic signed [COEF_W-1:0] RST_GAIN_A10  = -32'sd144828128;
   localparam logic signed [COEF_W-1:0] RST_GAIN_A11  = 32'sd15960651;
   localparam logic signed [COEF_W-1:0] RST_INJECT_C0 = 32'sd9092458;
   localparam logic signed [COEF_W-1:0] RST_INJECT_C1 = 32'sd144828128;
   localparam logic signed [COEF_W-1:0] RST_STEP_TIME = 32'sd167772;

   typedef struct packed {
      logic signed [COEF_W-1:0] gain_a00;
      logic signed [COEF_W-1:0] gain_a01;
      logic signed [COEF_W-1:0] gain_a10;
      logic signed [COEF_W-1:0] gain_a11;
      logic signed [COEF_W-1:0] inject_c0;
      logic signed [COEF_W-1:0] inject_c1;
      logic signed [COEF_W-1:0] step_time;
   } coef_type;

   typedef struct packed {
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] vehicle_x;
      logic signed [31:0] vehicle_y;
      logic signed [31:0] vehicle_z;
      logic signed [31:0] vehicle_vx;
      logic signed [31:0] vehicle_vy;
      logic signed [31:0] vehicle_vz;
      logic               use_measurement;
      logic               target_lost;
      logic signed [31:0] desired_yaw;
   } req_type;

   typedef struct packed {
      logic signed [31:0] est_err_x;
      logic signed [31:0] est_err_vx;
      logic signed [31:0] est_err_y;
      logic signed [31:0] est_err_vy;
      logic signed [31:0] est_err_z;
      logic signed [31:0] est_err_vz;
      logic signed [31:0] meas_err_x;
      logic signed [31:0] meas_err_y;
      logic signed [31:0] meas_err_z;
      logic               lost_out;
      logic signed [31:0] yaw_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_LOAD
   } state_type;

   // Lane sequence: four multiply issue phases, then the final accumulate
   typedef enum logic [2:0] {
      PH_MUL0,
      PH_MUL1,
      PH_MUL2,
      PH_MUL3,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic      active;
      phase_type phase;
      logic      init;
      logic      use_meas;
   } lane_ctrl_type;

   localparam logic signed [ACC_W-1:0] DATA_MAX = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] DATA_MIN = -DATA_MAX - 64'sd1;

   // Clamp a wide sum to the signed data range
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > DATA_MAX) begin
         r = DATA_MAX[DATA_W-1:0];
      end else if (x < DATA_MIN) begin
         r = DATA_MIN[DATA_W-1:0];
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // a - b, saturated to 32 bits
   function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [32:0] d;
      logic signed [31:0] r;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) begin
         r = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = d[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/delayed_target_predictive_observer_unit.sv
// Top level of the delayed-target predictive observer: control, lanes and result merge.
`default_nettype none

// Constant-velocity observer with open-loop prediction, one lane per axis.
// Each request transaction carries target, vehicle position and velocity,
// flags and yaw; each one yields exactly one response transaction with the
// estimate minus vehicle state, the measured error, and the lost flag and yaw
// passed through, all error terms saturated to 32 bits. Data is Q15.16 and
// coefficients are Q8.24. The first transaction after reset, and any one that
// reacquires a lost target, loads each estimate with the measurement and zero
// velocity. A transaction is accepted in idle, passes through the lanes in run
// (two multipliers per lane issue over four phases, with the last products
// accumulated in the fifth), and is merged into the response register in load,
// which waits while an earlier response is not yet taken. The request side
// reopens once the response is registered, so the next transaction is taken
// while the previous response still waits for rsp_ready. Configuration
// registers must be written via csr_we/csr_addr/csr_wdata only while no
// transaction is in flight, not enforced by the block; other indexes are ignored.
module delayed_target_predictive_observer_unit
   import dtpo_pkg::*;
#(
   parameter int AXES = AXES_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire                        csr_we,
   input  wire  [CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [COEF_W-1:0]          csr_wdata
);

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   coef_type      coef_ff;
   req_type       item_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;
   logic          init_ff, use_meas_ff;
   logic          was_lost_ff, needs_init_ff;
   logic          accept, load_out;
   lane_ctrl_type lane_ctrl;

   logic signed [DATA_W-1:0] meas_arr [OUT_AXES];
   logic signed [DATA_W-1:0] veh_arr  [OUT_AXES];
   logic signed [DATA_W-1:0] vvel_arr [OUT_AXES];
   logic signed [DATA_W-1:0] lane_pos [AXES];
   logic signed [DATA_W-1:0] lane_vel [AXES];
   logic signed [DATA_W-1:0] out_pos  [OUT_AXES];
   logic signed [DATA_W-1:0] out_vel  [OUT_AXES];

   assign accept = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.gain_a00  <= RST_GAIN_A00;
         coef_ff.gain_a01  <= RST_GAIN_A01;
         coef_ff.gain_a10  <= RST_GAIN_A10;
         coef_ff.gain_a11  <= RST_GAIN_A11;
         coef_ff.inject_c0 <= RST_INJECT_C0;
         coef_ff.inject_c1 <= RST_INJECT_C1;
         coef_ff.step_time <= RST_STEP_TIME;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GAIN_A00:  coef_ff.gain_a00  <= csr_wdata;
            CSR_GAIN_A01:  coef_ff.gain_a01  <= csr_wdata;
            CSR_GAIN_A10:  coef_ff.gain_a10  <= csr_wdata;
            CSR_GAIN_A11:  coef_ff.gain_a11  <= csr_wdata;
            CSR_INJECT_C0: coef_ff.inject_c0 <= csr_wdata;
            CSR_INJECT_C1: coef_ff.inject_c1 <= csr_wdata;
            CSR_STEP_TIME: coef_ff.step_time <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (phase_ff == PH_DONE) state_in = ST_LOAD;
         ST_LOAD: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready          = 1'b0;
      load_out           = 1'b0;
      lane_ctrl.active   = 1'b0;
      lane_ctrl.phase    = phase_ff;
      lane_ctrl.init     = init_ff;
      lane_ctrl.use_meas = use_meas_ff;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_RUN:  lane_ctrl.active = 1'b1;
         ST_LOAD: load_out = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // Advance the lane phase while running, park it otherwise
   always_comb begin
      phase_in = PH_MUL0;
      if (state_ff == ST_RUN) begin
         case (phase_ff)
            PH_MUL0: phase_in = PH_MUL1;
            PH_MUL1: phase_in = PH_MUL2;
            PH_MUL2: phase_in = PH_MUL3;
            PH_MUL3: phase_in = PH_DONE;
            default: phase_in = PH_MUL0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_MUL0;
         was_lost_ff   <= 1'b1;
         needs_init_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (accept) begin
            // Lost flag tracks the latest transaction; one transaction consumes init
            was_lost_ff   <= req_payload.target_lost;
            needs_init_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the accepted transaction and its mode for the lanes
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff     <= req_payload;
         use_meas_ff <= req_payload.use_measurement;
         // Initialize on the first transaction or on reacquire
         init_ff     <= needs_init_ff || (!req_payload.target_lost && was_lost_ff);
      end
   end

   assign meas_arr[0] = item_ff.target_x;
   assign meas_arr[1] = item_ff.target_y;
   assign meas_arr[2] = item_ff.target_z;
   assign veh_arr[0]  = item_ff.vehicle_x;
   assign veh_arr[1]  = item_ff.vehicle_y;
   assign veh_arr[2]  = item_ff.vehicle_z;
   assign vvel_arr[0] = item_ff.vehicle_vx;
   assign vvel_arr[1] = item_ff.vehicle_vy;
   assign vvel_arr[2] = item_ff.vehicle_vz;

   // Axis lanes; lanes past the measured axes see a zero measurement
   for (genvar i = 0; i < AXES; i++) begin : g_lane
      logic signed [DATA_W-1:0] lane_meas;
      if (i < OUT_AXES) begin : g_meas
         assign lane_meas = meas_arr[i];
      end else begin : g_zero
         assign lane_meas = '0;
      end
      dtpo_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .coef    (coef_ff),
         .meas    (lane_meas),
         .est_pos (lane_pos[i]),
         .est_vel (lane_vel[i])
      );
   end

   // Merge: reported axes without a lane read as zero estimate
   for (genvar i = 0; i < OUT_AXES; i++) begin : g_merge
      if (i < AXES) begin : g_have
         assign out_pos[i] = lane_pos[i];
         assign out_vel[i] = lane_vel[i];
      end else begin : g_none
         assign out_pos[i] = '0;
         assign out_vel[i] = '0;
      end
   end

   always_comb begin
      rsp_in.est_err_x  = sat_diff(out_pos[0], veh_arr[0]);
      rsp_in.est_err_vx = sat_diff(out_vel[0], vvel_arr[0]);
      rsp_in.est_err_y  = sat_diff(out_pos[1], veh_arr[1]);
      rsp_in.est_err_vy = sat_diff(out_vel[1], vvel_arr[1]);
      rsp_in.est_err_z  = sat_diff(out_pos[2], veh_arr[2]);
      rsp_in.est_err_vz = sat_diff(out_vel[2], vvel_arr[2]);
      rsp_in.meas_err_x = sat_diff(meas_arr[0], veh_arr[0]);
      rsp_in.meas_err_y = sat_diff(meas_arr[1], veh_arr[1]);
      rsp_in.meas_err_z = sat_diff(meas_arr[2], veh_arr[2]);
      rsp_in.lost_out   = item_ff.target_lost;
      rsp_in.yaw_out    = item_ff.desired_yaw;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> !$rose(rsp_valid_ff))
      else $error("response raised right after a request was accepted");

   a_init_consumed: assert property (@(posedge clock) disable iff (reset)
      accept |=> !needs_init_ff)
      else $error("initialization request not cleared by a transaction");

   a_lost_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> was_lost_ff == $past(req_payload.target_lost))
      else $error("lost flag does not follow the accepted transaction");

   a_phase_parked: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> phase_ff == PH_MUL0)
      else $error("lane phase advanced outside the run state");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      load_out |=> state_ff == ST_IDLE)
      else $error("response load did not return to idle");
`endif

endmodule

`default_nettype wire

### hdl/dtpo_lane.sv
// One axis lane: position/velocity estimate and its two-multiplier update sequence.
`default_nettype none

module dtpo_lane
   import dtpo_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire lane_ctrl_type        ctrl,
   input  wire coef_type             coef,
   input  wire logic signed [DATA_W-1:0] meas,
   output logic signed [DATA_W-1:0]  est_pos,
   output logic signed [DATA_W-1:0]  est_vel
);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

   logic signed [DATA_W-1:0] pos_ff, vel_ff, pred_ff, pred_in;
   logic signed [ACC_W-1:0]  prod_a_ff, prod_b_ff, acc_p_ff, acc_v_ff;
   logic signed [ACC_W-1:0]  prod_a_in, prod_b_in;
   logic signed [ACC_W-1:0]  rnd_a, rnd_b;
   logic signed [COEF_W-1:0] op_ca, op_cb;
   logic signed [DATA_W-1:0] op_da, op_db;

   // Round to nearest, ties away from zero
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] s;
      s = x + (x[ACC_W-1] ? HALF - 64'sd1 : HALF);
      return s >>> COEF_FRAC;
   endfunction

   assign rnd_a = rnd(prod_a_ff);
   assign rnd_b = rnd(prod_b_ff);

   // Operand select per phase
   always_comb begin
      op_ca = coef.gain_a00;
      op_da = pos_ff;
      op_cb = coef.gain_a00;
      op_db = pos_ff;
      case (ctrl.phase)
         PH_MUL0: begin
            op_ca = coef.step_time;
            op_da = vel_ff;
            op_cb = coef.gain_a00;
            op_db = pos_ff;
         end
         PH_MUL1: begin
            op_ca = coef.gain_a01;
            op_da = vel_ff;
            op_cb = coef.gain_a10;
            op_db = pos_ff;
         end
         PH_MUL2: begin
            op_ca = coef.inject_c0;
            op_da = pred_ff;
            op_cb = coef.gain_a11;
            op_db = vel_ff;
         end
         PH_MUL3: begin
            op_ca = coef.inject_c1;
            op_da = pred_ff;
         end
         default: begin
         end
      endcase
   end

   assign prod_a_in = ACC_W'(op_ca) * ACC_W'(op_da);
   assign prod_b_in = ACC_W'(op_cb) * ACC_W'(op_db);

   assign pred_in = ctrl.use_meas ? meas : sat_data(ACC_W'(pos_ff) + rnd_a);

   always_ff @(posedge clock) begin
      if (ctrl.active) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         case (ctrl.phase)
            PH_MUL1: begin
               pred_ff  <= pred_in;
               acc_p_ff <= rnd_b;
            end
            PH_MUL2: begin
               acc_p_ff <= acc_p_ff + rnd_a;
               acc_v_ff <= rnd_b;
            end
            PH_MUL3: begin
               acc_p_ff <= acc_p_ff + rnd_a;
               acc_v_ff <= acc_v_ff + rnd_b;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
      end else if (ctrl.active && ctrl.phase == PH_DONE) begin
         if (ctrl.init) begin
            pos_ff <= meas;
            vel_ff <= '0;
         end else begin
            pos_ff <= sat_data(acc_p_ff);
            vel_ff <= sat_data(acc_v_ff + rnd_a);
         end
      end
   end

   assign est_pos = pos_ff;
   assign est_vel = vel_ff;

endmodule

`default_nettype wire
